>>> hw/rtl/ddgp_pkg.sv
`timescale 1ns / 1ps
package ddgp_pkg;

    // Input pose transfer
    typedef struct packed {
        logic signed [23:0] cur_x;
        logic signed [23:0] cur_y;
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [23:0] goal_x;
        logic signed [23:0] goal_y;
    } t_pose;

    // Output command transfer
    typedef struct packed {
        logic [1:0]         left_dir;
        logic [16:0]        left_duty;
        logic [1:0]         right_dir;
        logic [16:0]        right_duty;
        logic [1:0]         phase;
        logic signed [15:0] heading_error;
        logic [24:0]        goal_range;
    } t_cmd;

    // Register indexes
    localparam logic [1:0] REG_ANGLE_TOL = 2'd0;
    localparam logic [1:0] REG_DIST_TOL  = 2'd1;
    localparam logic [1:0] REG_ANG_GAIN  = 2'd2;
    localparam logic [1:0] REG_LIN_GAIN  = 2'd3;

    // Wheel direction and phase codes
    localparam logic [1:0] DIR_STOP = 2'd0;
    localparam logic [1:0] DIR_FWD  = 2'd1;
    localparam logic [1:0] DIR_BACK = 2'd2;
    localparam logic [1:0] PH_ROTATE = 2'd0;
    localparam logic [1:0] PH_DRIVE  = 2'd1;
    localparam logic [1:0] PH_REACHED = 2'd2;

    localparam int ZW = 22;      // CORDIC angle width, 2^-16 rad
    localparam int CW = 36;      // CORDIC x/y width
    localparam logic signed [ZW-1:0] PI_Z = 22'sd205887;
    localparam logic signed [17:0] PI_Q = 18'sd25736;
    localparam logic signed [17:0] TWO_PI_Q = 18'sd51472;
    localparam logic [16:0] DUTY_FULL = 17'd65536;

    // Arctangent table in units of 2^-16 rad
    function automatic logic signed [ZW-1:0] atan_tab(input int i);
        logic signed [ZW-1:0] t;
        begin
            case (i)
                0: t = 22'sd51472;
                1: t = 22'sd30386;
                2: t = 22'sd16055;
                3: t = 22'sd8150;
                4: t = 22'sd4091;
                5: t = 22'sd2047;
                6: t = 22'sd1024;
                7: t = 22'sd512;
                8: t = 22'sd256;
                9: t = 22'sd128;
                10: t = 22'sd64;
                11: t = 22'sd32;
                12: t = 22'sd16;
                13: t = 22'sd8;
                14: t = 22'sd4;
                15: t = 22'sd2;
                16: t = 22'sd1;
                default: t = '0;
            endcase
            return t;
        end
    endfunction

endpackage

>>> hw/rtl/ddgp_cordic.sv
`timescale 1ns / 1ps
// Pipelined CORDIC vectoring atan2, one stage per register
module ddgp_cordic
    import ddgp_pkg::*;
#(
    parameter int STAGES = 16
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic signed [CW-1:0]  i_y,
    input  logic signed [CW-1:0]  i_x,
    output logic signed [15:0]    o_ang
);
    logic signed [CW-1:0] r_x [STAGES+1];
    logic signed [CW-1:0] r_y [STAGES+1];
    logic signed [ZW-1:0] r_z [STAGES+1];
    logic                 r_zero [STAGES+1];
    logic signed [ZW-1:0] w_zr;

    // Pre-rotation into the right half-plane
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= (i_x == 0) && (i_y == 0);
            if (i_x < 0) begin
                r_x[0] <= -i_x;
                r_y[0] <= -i_y;
                r_z[0] <= (i_y >= 0) ? PI_Z : -PI_Z;
            end else begin
                r_x[0] <= i_x;
                r_y[0] <= i_y;
                r_z[0] <= '0;
            end
        end
    end

    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zero[g+1] <= r_zero[g];
                if (r_y[g] > 0) begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] + atan_tab(g);
                end else if (r_y[g] < 0) begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] - atan_tab(g);
                end else begin
                    r_x[g+1] <= r_x[g];
                    r_y[g+1] <= r_y[g];
                    r_z[g+1] <= r_z[g];
                end
            end
        end
    end

    // Round to Q2.13
    assign w_zr = (r_z[STAGES] + ZW'(4)) >>> 3;
    assign o_ang = r_zero[STAGES] ? '0 : 16'(w_zr);
endmodule

>>> hw/rtl/ddgp_isqrt.sv
`timescale 1ns / 1ps
// Pipelined restoring square root of a 50-bit value, one result bit per stage
module ddgp_isqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [49:0] i_v,
    output logic [24:0] o_root
);
    localparam int N = 25;
    logic [49:0] r_rem [N+1];
    logic [24:0] r_rt [N+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_v;
            r_rt[0] <= '0;
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_bit
        localparam int B = N - 1 - g;
        logic [51:0] w_trial;
        assign w_trial = ({27'd0, r_rt[g]} << (B + 1)) + (52'd1 << (2 * B));
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if ({2'd0, r_rem[g]} >= w_trial) begin
                    r_rem[g+1] <= r_rem[g] - 50'(w_trial);
                    r_rt[g+1] <= r_rt[g] | (25'd1 << B);
                end else begin
                    r_rem[g+1] <= r_rem[g];
                    r_rt[g+1] <= r_rt[g];
                end
            end
        end
    end

    assign o_root = r_rt[N];
endmodule

>>> hw/rtl/diff_drive_goto_point_controller.sv
`timescale 1ns / 1ps
// Channel | direction | payload | handshake
// pose    | in        | t_pose  | i_pose_valid / o_pose_ready
// cmd     | out       | t_cmd   | o_cmd_valid / i_cmd_ready
// cfg     | in        | 23 bits | i_cfg_we, i_cfg_idx
// One pose per cycle unless the output stalls. Pose-to-command-valid delay is
// set by the square root path: deltas, squares, 25-stage root, wrap, products
// and output register. The CORDIC (CORDIC_STAGES + 1 stages) is delay-matched.
// The whole pipeline advances when the output register is free or being taken.
// Reset clears valid bits and loads the register defaults.
module diff_drive_goto_point_controller
    import ddgp_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_pose_valid,
    output logic        o_pose_ready,
    input  t_pose       i_pose,
    output logic        o_cmd_valid,
    input  logic        i_cmd_ready,
    output t_cmd        o_cmd,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [22:0] i_cfg_data
);
    localparam int CL = CORDIC_STAGES + 1;   // cordic registers after stage 1
    localparam int SL = 26;                  // sqrt registers
    localparam int DEPTH = SL + 6;           // valid stages through output

    logic [14:0] r_ang_tol;
    logic [22:0] r_dist_tol;
    logic [15:0] r_ang_gain;
    logic [15:0] r_lin_gain;
    logic        w_adv;
    logic [DEPTH-1:0] r_vld;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ang_tol <= 15'd819;
            r_dist_tol <= 23'd6554;
            r_ang_gain <= 16'd256;
            r_lin_gain <= 16'd256;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ANGLE_TOL: r_ang_tol <= i_cfg_data[14:0];
                REG_DIST_TOL:  r_dist_tol <= i_cfg_data;
                REG_ANG_GAIN:  r_ang_gain <= i_cfg_data[15:0];
                REG_LIN_GAIN:  r_lin_gain <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign w_adv = !o_cmd_valid || i_cmd_ready;
    assign o_pose_ready = w_adv;

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[DEPTH-2:0], i_pose_valid};
        end
    end
    assign o_cmd_valid = r_vld[DEPTH-1];

    // Stage 1: quaternion products and deltas
    logic signed [31:0] r_pwz, r_pxy, r_pyy, r_pzz;
    logic signed [24:0] r_dx, r_dy;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pwz <= i_pose.quat_w * i_pose.quat_z;
            r_pxy <= i_pose.quat_x * i_pose.quat_y;
            r_pyy <= i_pose.quat_y * i_pose.quat_y;
            r_pzz <= i_pose.quat_z * i_pose.quat_z;
            r_dx <= 25'(i_pose.goal_x) - 25'(i_pose.cur_x);
            r_dy <= 25'(i_pose.goal_y) - 25'(i_pose.cur_y);
        end
    end

    // Stage 2 feeds: yaw vector, bearing vector, squared distance terms
    logic signed [CW-1:0] w_num, w_den, w_by, w_bx;
    logic [49:0] r_dx2, r_dy2;
    assign w_num = (CW'(r_pwz) + CW'(r_pxy)) <<< 1;
    assign w_den = (CW'(1) <<< 28) - ((CW'(r_pyy) + CW'(r_pzz)) <<< 1);
    assign w_by = CW'(r_dy) <<< 8;
    assign w_bx = CW'(r_dx) <<< 8;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dx2 <= 50'(r_dx * r_dx);
            r_dy2 <= 50'(r_dy * r_dy);
        end
    end

    logic signed [15:0] w_yaw, w_brg;
    ddgp_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
        .i_clk(i_clk), .i_en(w_adv), .i_y(w_num), .i_x(w_den), .o_ang(w_yaw)
    );
    ddgp_cordic #(.STAGES(CORDIC_STAGES)) u_brg (
        .i_clk(i_clk), .i_en(w_adv), .i_y(w_by), .i_x(w_bx), .o_ang(w_brg)
    );

    // Distance: sqrt input comes from the registered squares
    logic [24:0] w_root;
    logic [24:0] r_root;
    logic [49:0] w_d2;
    assign w_d2 = r_dx2 + r_dy2;
    ddgp_isqrt u_sqrt (.i_clk(i_clk), .i_en(w_adv), .i_v(w_d2), .o_root(w_root));
    // sqrt output appears at stage 1+1+SL; cordic at stage 1+CL
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_root <= w_root;
        end
    end

    // The sqrt chain (1 + SL) outruns cordic (CL) so cordic results are delayed
    localparam int CD = (SL + 2) - (CL + 1);
    logic signed [15:0] r_yd [CD+1];
    logic signed [15:0] r_bd [CD+1];
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_yd[0] <= w_yaw;
            r_bd[0] <= w_brg;
        end
    end
    for (genvar g = 0; g < CD; g++) begin : g_cd
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_yd[g+1] <= r_yd[g];
                r_bd[g+1] <= r_bd[g];
            end
        end
    end
    // Note: r_root aligns with r_yd[CD].

    // Heading error wrap stage
    logic signed [17:0] w_e0, w_e1, w_err;
    logic signed [17:0] r_err;
    logic [24:0] r_dist;
    assign w_e0 = 18'(r_bd[CD]) - 18'(r_yd[CD]);
    assign w_e1 = (w_e0 > PI_Q) ? w_e0 - TWO_PI_Q : w_e0;
    assign w_err = (w_e1 < -PI_Q) ? w_e1 + TWO_PI_Q : w_e1;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_err <= w_err;
            r_dist <= r_root;
        end
    end

    // Products and command
    logic [17:0] w_abs;
    logic        r_rot, r_drv, r_neg;
    logic [33:0] r_av;
    logic [40:0] r_lv;
    logic signed [17:0] r_err2;
    logic [24:0] r_dist2;
    assign w_abs = r_err[17] ? 18'(-r_err) : r_err;
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_rot <= w_abs > 18'(r_ang_tol);
            r_drv <= r_dist > 25'(r_dist_tol);
            r_neg <= r_err[17] && (r_ang_gain != 0);
            r_av <= 34'(w_abs) * 34'(r_ang_gain);
            r_lv <= 41'(r_dist) * 41'(r_lin_gain);
            r_err2 <= r_err;
            r_dist2 <= r_dist;
        end
    end

    logic [33:0] w_am;
    logic [40:0] w_lm;
    t_cmd w_cmd;
    t_cmd r_cmd;
    assign w_am = r_av >> 5;
    assign w_lm = r_lv >> 8;
    always_comb begin
        w_cmd = '0;
        w_cmd.heading_error = 16'(r_err2);
        w_cmd.goal_range = r_dist2;
        if (r_rot) begin
            w_cmd.phase = PH_ROTATE;
            w_cmd.left_duty = (w_am > 34'(DUTY_FULL)) ? DUTY_FULL : 17'(w_am);
            w_cmd.left_dir = r_neg ? DIR_FWD : DIR_BACK;
            w_cmd.right_dir = r_neg ? DIR_BACK : DIR_FWD;
        end else if (r_drv) begin
            w_cmd.phase = PH_DRIVE;
            w_cmd.left_duty = (w_lm > 41'(DUTY_FULL)) ? DUTY_FULL : 17'(w_lm);
            w_cmd.left_dir = DIR_FWD;
            w_cmd.right_dir = DIR_FWD;
        end else begin
            w_cmd.phase = PH_REACHED;
            w_cmd.left_dir = DIR_STOP;
            w_cmd.right_dir = DIR_STOP;
        end
        w_cmd.right_duty = w_cmd.left_duty;
    end
    always_ff @(posedge i_clk) begin
        if (w_adv) r_cmd <= w_cmd;
    end
    assign o_cmd = r_cmd;
endmodule

>>> hw/rtl/ddgp_checker.sv
`timescale 1ns / 1ps
module ddgp_checker
    import ddgp_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_cmd_valid,
    input logic i_cmd_ready,
    input logic o_pose_ready,
    input t_cmd o_cmd
);
    // Stalled command holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_valid && !i_cmd_ready |=> o_cmd_valid && $stable(o_cmd))
        else $error("command changed under stall");
    // Both wheels share one duty
    a_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_valid |-> o_cmd.left_duty == o_cmd.right_duty)
        else $error("duty mismatch");
    // Reached means stopped
    a_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_valid && o_cmd.phase == PH_REACHED |->
        o_cmd.left_dir == DIR_STOP && o_cmd.left_duty == 0)
        else $error("reached but moving");
    // Ready when output is free
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_cmd_valid |-> o_pose_ready)
        else $error("stalled while empty");
endmodule

bind diff_drive_goto_point_controller ddgp_checker u_ddgp_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_cmd_valid(o_cmd_valid),
    .i_cmd_ready(i_cmd_ready), .o_pose_ready(o_pose_ready), .o_cmd(o_cmd)
);
